// ===== hw/rtl/sfr_pkg.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sfr_pkg
// Shared types, constants and helpers for the stream find-and-replace block.
// ---------------------------------------------------------------------------
package sfr_pkg;

   localparam int PATTERN_MAX     = 16;
   localparam int REPLACEMENT_MAX = 16;
   localparam int LEN_W           = 5;
   localparam int IDX_W           = 4;
   localparam int POS_W           = 32;
   localparam int FMS_W           = 33;
   localparam int CSR_INDEX_W     = 3;
   localparam int CSR_DATA_W      = 64;
   localparam int QUEUE_DEPTH     = 4;
   localparam int QPTR_W          = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W          = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LO    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_HI    = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAT_LEN   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_REP_LO    = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_REP_HI    = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_REP_LEN   = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_ONLY = 3'd6;

   localparam logic [LEN_W-1:0] PAT_LEN_RESET = 5'd1;
   localparam logic [FMS_W-1:0] NO_MATCH      = '1;

   typedef struct packed {
      logic [63:0]      pat_lo;
      logic [63:0]      pat_hi;
      logic [LEN_W-1:0] pat_len;
      logic [63:0]      rep_lo;
      logic [63:0]      rep_hi;
      logic [LEN_W-1:0] rep_len;
      logic             first_only;
   } cfg_type;

   // One unit of work for the back end: cnt bytes from the pattern or the
   // replacement text, then optionally the source byte.
   typedef struct packed {
      logic             rep;
      logic [LEN_W-1:0] cnt;
      logic             has_byte;
      logic [7:0]       data;
      logic             last;
      logic [FMS_W-1:0] fms;
   } cmd_type;

   function automatic logic [7:0] pick_byte(logic [63:0] lo, logic [63:0] hi,
                                            logic [IDX_W-1:0] k);
      logic [63:0] word;
      word = k[3] ? hi : lo;
      return word[{k[2:0], 3'b000} +: 8];
   endfunction

   function automatic logic [LEN_W-1:0] sat_len(logic [LEN_W-1:0] len, int max);
      logic [LEN_W-1:0] lim;
      lim = LEN_W'(max);
      return (len > lim) ? lim : len;
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/sfr_front.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sfr_front
// Matches each request byte against the pattern and issues work commands.
// ---------------------------------------------------------------------------
module sfr_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire sfr_pkg::cfg_type  cfg,
   input  wire logic              req_valid,
   input  wire logic              req_stall,
   input  wire logic [7:0]        req_in_byte,
   input  wire logic              req_in_last,
   output logic                   push,
   output sfr_pkg::cmd_type       cmd
);

   logic [sfr_pkg::IDX_W-1:0] mc_ff, mc_in;
   logic [sfr_pkg::POS_W-1:0] pos_ff, pos_in;
   logic                      found_ff, found_in;
   logic [sfr_pkg::POS_W-1:0] fpos_ff, fpos_in;

   logic [sfr_pkg::LEN_W-1:0] plen, rlen, mc_ext, mc_next;
   logic                      accept, enabled, hit, full;
   logic                      found_new;
   logic [sfr_pkg::POS_W-1:0] fpos_new;

   always_comb begin
      plen    = sfr_pkg::sat_len(cfg.pat_len, sfr_pkg::PATTERN_MAX);
      rlen    = sfr_pkg::sat_len(cfg.rep_len, sfr_pkg::REPLACEMENT_MAX);
      mc_ext  = {1'b0, mc_ff};
      mc_next = mc_ext + 5'd1;
      accept  = req_valid && !req_stall;
      enabled = (plen != '0) && !(cfg.first_only && found_ff) && (mc_ext < plen);
      hit     = enabled &&
                (req_in_byte == sfr_pkg::pick_byte(cfg.pat_lo, cfg.pat_hi, mc_ff));
      full    = hit && (mc_next == plen);

      found_new = found_ff;
      fpos_new  = fpos_ff;
      if (full && !found_ff) begin
         found_new = 1'b1;
         fpos_new  = pos_ff - sfr_pkg::POS_W'(plen) + 32'd1;
      end

      cmd.data = req_in_byte;
      cmd.last = req_in_last;
      cmd.fms  = found_new ? {1'b0, fpos_new} : sfr_pkg::NO_MATCH;
      if (full) begin
         cmd.rep      = 1'b1;
         cmd.cnt      = rlen;
         cmd.has_byte = 1'b0;
         mc_in        = '0;
      end else if (hit) begin
         cmd.rep      = 1'b0;
         cmd.cnt      = req_in_last ? mc_next : '0;
         cmd.has_byte = 1'b0;
         mc_in        = mc_next[sfr_pkg::IDX_W-1:0];
      end else begin
         cmd.rep      = 1'b0;
         cmd.cnt      = mc_ext;
         cmd.has_byte = 1'b1;
         mc_in        = '0;
      end

      push = accept && (req_in_last || cmd.has_byte || (cmd.cnt != '0));

      if (req_in_last) begin
         mc_in    = '0;
         pos_in   = '0;
         found_in = 1'b0;
      end else begin
         pos_in   = pos_ff + 32'd1;
         found_in = found_new;
      end
      fpos_in = fpos_new;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mc_ff    <= '0;
         pos_ff   <= '0;
         found_ff <= 1'b0;
      end else if (accept) begin
         mc_ff    <= mc_in;
         pos_ff   <= pos_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fpos_ff <= fpos_in;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sfr_queue.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sfr_queue
// Small command queue between the matcher and the output sequencer.
// ---------------------------------------------------------------------------
module sfr_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire sfr_pkg::cmd_type  push_cmd,
   input  wire logic              pop,
   output logic                   full,
   output logic                   head_valid,
   output sfr_pkg::cmd_type       head_cmd
);

   sfr_pkg::cmd_type             q_ff [sfr_pkg::QUEUE_DEPTH];
   logic [sfr_pkg::QPTR_W-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [sfr_pkg::QCNT_W-1:0]   cnt_ff, cnt_in;
   logic                         do_pop;

   always_comb begin
      full       = (cnt_ff == sfr_pkg::QCNT_W'(sfr_pkg::QUEUE_DEPTH));
      head_valid = (cnt_ff != '0);
      head_cmd   = q_ff[rd_ff];
      do_pop     = pop && head_valid;
      wr_in      = push ? wr_ff + 1'b1 : wr_ff;
      rd_in      = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in     = cnt_ff + sfr_pkg::QCNT_W'(push) - sfr_pkg::QCNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/sfr_back.sv =====
`default_nettype none
// ---------------------------------------------------------------------------
// sfr_back
// Expands queued commands into response bytes, one per cycle while the response side is not stalled.
// ---------------------------------------------------------------------------
module sfr_back (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire sfr_pkg::cfg_type          cfg,
   input  wire logic                      head_valid,
   input  wire sfr_pkg::cmd_type          head_cmd,
   output logic                           pop,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [7:0]                     rsp_out_byte,
   output logic                           rsp_out_byte_valid,
   output logic                           rsp_from_replacement,
   output logic                           rsp_out_last,
   output logic signed [sfr_pkg::FMS_W-1:0] rsp_first_match_start
);

   logic [sfr_pkg::IDX_W-1:0]  step_ff, step_in;
   logic                       valid_ff, valid_in;
   logic [7:0]                 byte_ff, byte_in;
   logic                       bval_ff, bval_in;
   logic                       repl_ff, repl_in;
   logic                       last_ff, last_in;
   logic [sfr_pkg::FMS_W-1:0]  fms_ff, fms_in;

   logic                       load, done;
   logic [sfr_pkg::LEN_W:0]    total, step_ext;

   always_comb begin
      load     = !valid_ff || !rsp_stall;
      total    = {1'b0, head_cmd.cnt} + {{sfr_pkg::LEN_W{1'b0}}, head_cmd.has_byte};
      step_ext = {2'b00, step_ff};
      done     = (total == '0) || (step_ext == total - 1'b1);
      pop      = load && head_valid && done;

      valid_in = valid_ff;
      step_in  = step_ff;
      byte_in  = byte_ff;
      bval_in  = bval_ff;
      repl_in  = repl_ff;
      last_in  = last_ff;
      fms_in   = fms_ff;

      if (load) begin
         valid_in = head_valid;
         if (head_valid) begin
            step_in = done ? '0 : step_ff + 1'b1;
            if (total == '0) begin
               byte_in = '0;
               bval_in = 1'b0;
               repl_in = 1'b0;
            end else if ({1'b0, step_ff} < head_cmd.cnt) begin
               byte_in = head_cmd.rep ?
                         sfr_pkg::pick_byte(cfg.rep_lo, cfg.rep_hi, step_ff) :
                         sfr_pkg::pick_byte(cfg.pat_lo, cfg.pat_hi, step_ff);
               bval_in = 1'b1;
               repl_in = head_cmd.rep;
            end else begin
               byte_in = head_cmd.data;
               bval_in = 1'b1;
               repl_in = 1'b0;
            end
            last_in = done && head_cmd.last;
            fms_in  = (done && head_cmd.last) ? head_cmd.fms : '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         valid_ff <= valid_in;
         step_ff  <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      bval_ff <= bval_in;
      repl_ff <= repl_in;
      last_ff <= last_in;
      fms_ff  <= fms_in;
   end

   assign rsp_valid             = valid_ff;
   assign rsp_out_byte          = byte_ff;
   assign rsp_out_byte_valid    = bval_ff;
   assign rsp_from_replacement  = repl_ff;
   assign rsp_out_last          = last_ff;
   assign rsp_first_match_start = fms_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/stream_find_replace.sv =====
`default_nettype none
// An accepted request's command goes through the command queue and then the
// output register. Throughput: one request per cycle while the 4-entry queue
// is not full; the sequencer emits one response per cycle unless rsp_stall
// holds it, up to 16 for a request, so the queue lets requests flow meanwhile.
// Reset: synchronous; clears match state, queue and output, and returns all
// registers to their reset values (pattern length 1, others 0).
// ---------------------------------------------------------------------------
// stream_find_replace
// Streaming byte find-and-replace with first-match position reporting.
// ---------------------------------------------------------------------------
module stream_find_replace (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire logic [7:0]                           req_in_byte,
   input  wire logic                                 req_in_last,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output logic [7:0]                                rsp_out_byte,
   output logic                                      rsp_out_byte_valid,
   output logic                                      rsp_from_replacement,
   output logic                                      rsp_out_last,
   output logic signed [sfr_pkg::FMS_W-1:0]          rsp_first_match_start,
   input  wire logic                                 csr_write_enable,
   input  wire logic [sfr_pkg::CSR_INDEX_W-1:0]      csr_index,
   input  wire logic [sfr_pkg::CSR_DATA_W-1:0]       csr_write_data
);

   sfr_pkg::cfg_type cfg_ff, cfg_in;
   sfr_pkg::cmd_type front_cmd, head_cmd;
   logic             push, pop, q_full, head_valid;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            sfr_pkg::CSR_PAT_LO:     cfg_in.pat_lo     = csr_write_data;
            sfr_pkg::CSR_PAT_HI:     cfg_in.pat_hi     = csr_write_data;
            sfr_pkg::CSR_PAT_LEN:    cfg_in.pat_len    = csr_write_data[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CSR_REP_LO:     cfg_in.rep_lo     = csr_write_data;
            sfr_pkg::CSR_REP_HI:     cfg_in.rep_hi     = csr_write_data;
            sfr_pkg::CSR_REP_LEN:    cfg_in.rep_len    = csr_write_data[sfr_pkg::LEN_W-1:0];
            sfr_pkg::CSR_FIRST_ONLY: cfg_in.first_only = csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pat_lo     <= '0;
         cfg_ff.pat_hi     <= '0;
         cfg_ff.pat_len    <= sfr_pkg::PAT_LEN_RESET;
         cfg_ff.rep_lo     <= '0;
         cfg_ff.rep_hi     <= '0;
         cfg_ff.rep_len    <= '0;
         cfg_ff.first_only <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req_stall = q_full;

   sfr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_in_byte (req_in_byte),
      .req_in_last (req_in_last),
      .push        (push),
      .cmd         (front_cmd)
   );

   sfr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (front_cmd),
      .pop        (pop),
      .full       (q_full),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   sfr_back u_back (
      .clock                 (clock),
      .reset                 (reset),
      .cfg                   (cfg_ff),
      .head_valid            (head_valid),
      .head_cmd              (head_cmd),
      .pop                   (pop),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_out_byte_valid    (rsp_out_byte_valid),
      .rsp_from_replacement  (rsp_from_replacement),
      .rsp_out_last          (rsp_out_last),
      .rsp_first_match_start (rsp_first_match_start)
   );

endmodule
`default_nettype wire

// ===== bench/stream_find_replace_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// stream_find_replace_tb
// Self-checking bench for the streaming find-and-replace block. Strings are
// fed one byte per request; a scoreboard object keeps its own copy of the
// match state and registers, predicts every output byte and end marker, and
// compares them field by field. Random idle gaps on the request side and
// random stalls on the response side.
// ---------------------------------------------------------------------------
module stream_find_replace_tb;
   import sfr_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 3'd7;
   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int PHASES         = 8;
   localparam int PHASE_ITEMS    = 18;

   typedef struct {
      logic [7:0]       data;
      logic             data_valid;
      logic             from_repl;
      logic             last;
      logic [FMS_W-1:0] first_start;
   } rewritten_byte_t;

   class rewrite_scoreboard;
      logic [63:0]      pat_lo, pat_hi, rep_lo, rep_hi;
      logic [LEN_W-1:0] pat_len, rep_len;
      logic             first_only;
      logic [LEN_W-1:0] held;
      logic [POS_W-1:0] position;
      logic [FMS_W-1:0] first_hit;
      rewritten_byte_t  pending_bytes[$];
      int               failures;

      function new();
         pat_lo     = '0;
         pat_hi     = '0;
         rep_lo     = '0;
         rep_hi     = '0;
         pat_len    = 5'd1;
         rep_len    = '0;
         first_only = 1'b0;
         held       = '0;
         position   = '0;
         first_hit  = NO_MATCH;
         failures   = 0;
      endfunction

      function logic [7:0] pattern_byte(int k);
         return 8'({pat_hi, pat_lo} >> (8 * (k % 16)));
      endfunction

      function logic [7:0] replacement_byte(int k);
         return 8'({rep_hi, rep_lo} >> (8 * (k % 16)));
      endfunction

      function int pattern_span();
         return (pat_len > 5'd16) ? 16 : int'(pat_len);
      endfunction

      function bit pending();
         return pending_bytes.size() != 0;
      endfunction

      function void append(logic [7:0] b, logic v, logic r);
         rewritten_byte_t item;
         item.data        = b;
         item.data_valid  = v;
         item.from_repl   = r;
         item.last        = 1'b0;
         item.first_start = '0;
         pending_bytes.push_back(item);
      endfunction

      function void flush_held();
         for (int k = 0; k < int'(held); k++) append(pattern_byte(k), 1'b1, 1'b0);
         held = '0;
      endfunction

      function void note_config(logic [CSR_INDEX_W-1:0] idx, logic [63:0] value);
         case (idx)
            CSR_PAT_LO:     pat_lo     = value;
            CSR_PAT_HI:     pat_hi     = value;
            CSR_PAT_LEN:    pat_len    = value[LEN_W-1:0];
            CSR_REP_LO:     rep_lo     = value;
            CSR_REP_HI:     rep_hi     = value;
            CSR_REP_LEN:    rep_len    = value[LEN_W-1:0];
            CSR_FIRST_ONLY: first_only = value[0];
            default: ;
         endcase
      endfunction

      function void take_request(logic [7:0] b, logic final_byte);
         int  plen, rlen, prior_count;
         bit  hit_seen, armed;
         plen        = pattern_span();
         rlen        = (rep_len > 5'd16) ? 16 : int'(rep_len);
         hit_seen    = first_hit != NO_MATCH;
         armed       = plen > 0 && !(first_only && hit_seen) && int'(held) < plen;
         prior_count = pending_bytes.size();
         if (armed && b == pattern_byte(int'(held))) begin
            held++;
            if (int'(held) == plen) begin
               if (!hit_seen) first_hit = {1'b0, position - POS_W'(plen) + 32'd1};
               for (int k = 0; k < rlen; k++) append(replacement_byte(k), 1'b1, 1'b1);
               held = '0;
            end
         end else begin
            flush_held();
            append(b, 1'b1, 1'b0);
         end
         if (final_byte) begin
            flush_held();
            if (pending_bytes.size() == prior_count) append(8'h00, 1'b0, 1'b0);
            pending_bytes[pending_bytes.size()-1].last        = 1'b1;
            pending_bytes[pending_bytes.size()-1].first_start = first_hit;
            position  = '0;
            first_hit = NO_MATCH;
         end else begin
            position++;
         end
      endfunction

      function void check_response(rewritten_byte_t got);
         rewritten_byte_t want;
         if (pending_bytes.size() == 0) begin
            $error("unexpected response: out_byte %h last %b", got.data, got.last);
            failures++;
            return;
         end
         want = pending_bytes.pop_front();
         if (got.data !== want.data) begin
            $error("out_byte: expected %h, got %h", want.data, got.data);
            failures++;
         end
         if (got.data_valid !== want.data_valid) begin
            $error("out_byte_valid: expected %b, got %b", want.data_valid, got.data_valid);
            failures++;
         end
         if (got.from_repl !== want.from_repl) begin
            $error("from_replacement: expected %b, got %b", want.from_repl, got.from_repl);
            failures++;
         end
         if (got.last !== want.last) begin
            $error("out_last: expected %b, got %b", want.last, got.last);
            failures++;
         end
         if (got.first_start !== want.first_start) begin
            $error("first_match_start: expected %0d, got %0d",
                   $signed(want.first_start), $signed(got.first_start));
            failures++;
         end
      endfunction
   endclass

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [7:0]               req_in_byte = 8'h00;
   logic                     req_in_last = 1'b0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [7:0]               rsp_out_byte;
   logic                     rsp_out_byte_valid;
   logic                     rsp_from_replacement;
   logic                     rsp_out_last;
   logic signed [FMS_W-1:0]  rsp_first_match_start;
   logic                     csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]    csr_write_data = '0;

   rewrite_scoreboard sb;
   rewritten_byte_t   observed;
   bit                steady_sender;
   int                stall_left;
   int                stall_roll;
   int                idle_cycles;

   stream_find_replace dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_in_byte           (req_in_byte),
      .req_in_last           (req_in_last),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_out_byte          (rsp_out_byte),
      .rsp_out_byte_valid    (rsp_out_byte_valid),
      .rsp_from_replacement  (rsp_from_replacement),
      .rsp_out_last          (rsp_out_last),
      .rsp_first_match_start (rsp_first_match_start),
      .csr_write_enable      (csr_write_enable),
      .csr_index             (csr_index),
      .csr_write_data        (csr_write_data)
   );

   always #5 clock = ~clock;

   // response back-pressure: free-running stretches, short stalls, rare long ones
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else if (stall_left == 0) begin
         stall_roll = $urandom_range(0, 9);
         if (stall_roll < 5) begin
            rsp_stall  <= 1'b0;
            stall_left <= $urandom_range(1, 30);
         end else if (stall_roll < 9) begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(1, 3);
         end else begin
            rsp_stall  <= 1'b1;
            stall_left <= $urandom_range(10, 40);
         end
      end else begin
         stall_left <= stall_left - 1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         observed.data        = rsp_out_byte;
         observed.data_valid  = rsp_out_byte_valid;
         observed.from_repl   = rsp_from_replacement;
         observed.last        = rsp_out_last;
         observed.first_start = rsp_first_match_start;
         sb.check_response(observed);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   task automatic send_request(input logic [7:0] value, input logic final_byte);
      int gap, roll;
      roll = $urandom_range(0, 19);
      if (steady_sender || roll < 12) gap = 0;
      else if (roll < 18) gap = $urandom_range(1, 3);
      else gap = $urandom_range(6, 25);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= value;
      req_in_last <= final_byte;
      do @(posedge clock); while (req_stall);
      sb.take_request(value, final_byte);
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending()) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= value;
      @(posedge clock);
      sb.note_config(idx, value);
   endtask

   task automatic set_register(input logic [CSR_INDEX_W-1:0] idx, input logic [63:0] value);
      settle();
      write_csr(idx, value);
      csr_write_enable <= 1'b0;
   endtask

   task automatic program_all(input logic [127:0] pat, input logic [63:0] plen_word,
                              input logic [127:0] rep, input logic [63:0] rlen_word,
                              input logic [63:0] fo_word);
      settle();
      write_csr(CSR_PAT_LO, pat[63:0]);
      write_csr(CSR_PAT_HI, pat[127:64]);
      write_csr(CSR_PAT_LEN, plen_word);
      write_csr(CSR_REP_LO, rep[63:0]);
      write_csr(CSR_REP_HI, rep[127:64]);
      write_csr(CSR_REP_LEN, rlen_word);
      write_csr(CSR_FIRST_ONLY, fo_word);
      csr_write_enable <= 1'b0;
   endtask

   initial begin : stimulus
      int          plen_v, rlen_v, fo_v, phase_items, target, roll, span, cut;
      logic [127:0] pat, rep;
      logic [7:0]  text[$];

      sb = new();
      steady_sender = 1'b0;
      idle_cycles   = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reset registers: single zero byte is deleted, also on the final byte
      send_request(8'h00, 1'b1);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b1);

      // "xyz" -> "AB": broken partial match, full match, partial at string end
      program_all({104'h0, 24'h7A7978}, 64'd3, {112'h0, 16'h4241}, 64'd2, 64'd0);
      send_request(8'h78, 1'b0);
      send_request(8'h79, 1'b0);
      send_request(8'h71, 1'b0);
      send_request(8'h78, 1'b0);
      send_request(8'h79, 1'b0);
      send_request(8'h7A, 1'b0);
      send_request(8'h78, 1'b0);
      send_request(8'h79, 1'b1);

      // first-only with full replacement text
      program_all({112'h0, 16'h00FF}, 64'd2, {$urandom, $urandom, $urandom, $urandom},
                  64'd16, 64'd1);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b1);

      // first-only switched on mid-string after a hit, oversize replacement length
      set_register(CSR_FIRST_ONLY, 64'd0);
      set_register(CSR_REP_LEN, 64'd31);
      send_request(8'hFF, 1'b0);
      send_request(8'h00, 1'b0);
      send_request(8'hFF, 1'b0);
      set_register(CSR_FIRST_ONLY, 64'd1);
      send_request(8'h00, 1'b1);

      // pattern shortened below the held count mid-string
      program_all({104'h0, 24'hCCBBAA}, 64'd3, {112'h0, 16'h5150}, 64'd2, 64'd0);
      send_request(8'hAA, 1'b0);
      send_request(8'hBB, 1'b0);
      set_register(CSR_PAT_LEN, 64'd1);
      send_request(8'hCC, 1'b1);

      // zero pattern length passes everything through
      set_register(CSR_PAT_LEN, 64'd0);
      send_request(8'h5A, 1'b0);
      send_request(8'hA5, 1'b1);

      for (int phase = 0; phase < PHASES; phase++) begin
         for (int k = 0; k < 16; k++)
            pat[8*k +: 8] = $urandom_range(0, 1) ? 8'(8'h41 + $urandom_range(0, 2))
                                                 : 8'($urandom_range(0, 255));
         rep = {$urandom, $urandom, $urandom, $urandom};
         roll = $urandom_range(0, 7);
         if (phase == 0) plen_v = 16;
         else if (phase == 1) plen_v = 1;
         else if (phase == 2) plen_v = $urandom_range(17, 31);
         else plen_v = (roll == 0) ? 0 : $urandom_range(1, 6);
         if (phase == 0) rlen_v = 16;
         else if (phase == 1) rlen_v = 0;
         else if (phase == 2) rlen_v = $urandom_range(17, 31);
         else rlen_v = $urandom_range(0, 6);
         if (phase == 0) fo_v = 0;
         else if (phase == 1) fo_v = 1;
         else fo_v = $urandom_range(0, 1);
         program_all(pat, {32'($urandom), 27'($urandom), 5'(plen_v)}, rep,
                     {32'($urandom), 27'($urandom), 5'(rlen_v)},
                     {32'($urandom), 31'($urandom), 1'(fo_v)});
         if (phase == 3) set_register(CSR_UNUSED, {$urandom, $urandom});

         phase_items = 0;
         while (phase_items < PHASE_ITEMS) begin
            text.delete();
            target = $urandom_range(1, 12);
            span   = sb.pattern_span();
            while (text.size() < target) begin
               roll = $urandom_range(0, 9);
               if (span > 0 && roll < 4) begin
                  for (int k = 0; k < span; k++) text.push_back(sb.pattern_byte(k));
               end else if (span > 1 && roll < 6) begin
                  cut = $urandom_range(1, span - 1);
                  for (int k = 0; k < cut; k++) text.push_back(sb.pattern_byte(k));
               end else if (roll < 8) begin
                  text.push_back(8'(8'h41 + $urandom_range(0, 2)));
               end else begin
                  text.push_back(8'($urandom_range(0, 255)));
               end
            end
            steady_sender = ($urandom_range(0, 3) == 0);
            foreach (text[i]) send_request(text[i], i == text.size() - 1);
            phase_items += text.size();
         end
         steady_sender = 1'b0;
      end

      settle();
      if (sb.failures == 0) $display("SUCCESS");
      else $display("FAILURE");
      $finish;
   end

endmodule

// ===== stream_find_replace.f =====
hw/rtl/sfr_pkg.sv
hw/rtl/sfr_front.sv
hw/rtl/sfr_queue.sv
hw/rtl/sfr_back.sv
hw/rtl/stream_find_replace.sv
bench/stream_find_replace_tb.sv
